// ----- hw/rtl/eih_pkg.sv -----
// Shared types and constants of the event interval histogram.
package eih_pkg;

	// Counters stop at this value instead of wrapping.
	localparam logic [31:0] SAT_COUNT = 32'hFFFF_FFFF;

	// One request: a timestamp event or a histogram bin read.
	typedef struct packed {
		logic        command;
		logic [31:0] time_sec;
		logic [29:0] time_nsec;
		logic [9:0]  bin_index;
	} eih_req_t;

	// One response to a request.
	typedef struct packed {
		logic [31:0] bin_count;
		logic [31:0] max_period_ms;
		logic        interval_recorded;
	} eih_rsp_t;

	// Request state handed from the interval pipeline to the bin update stage.
	typedef struct packed {
		logic        valid;
		logic        is_read;
		logic        recorded;
		logic        oob;
		logic [31:0] ms;
	} eih_op_t;

	// Request commands.
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

endpackage

// ----- hw/rtl/eih_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module eih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/eih_interval.sv -----
// Event counting and millisecond interval pipeline that picks the histogram bin.
module eih_interval #(
	parameter int NUM_BINS = 1024,
	localparam int AW = $clog2(NUM_BINS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             accept,
	input  eih_pkg::eih_req_t req,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	output eih_pkg::eih_op_t op,
	output logic [AW-1:0]    addr
);

	import eih_pkg::*;

	// Offset that keeps the biased nanosecond term nonnegative.
	localparam logic [31:0] NSEC_BIAS  = 32'd1074999999;
	localparam logic [11:0] BIAS_MS    = 12'd1074;
	// Reciprocal of one million, exact for 32-bit dividends with a shift of 50.
	localparam logic [31:0] RECIP_MS   = 32'h431B_DE83;
	localparam logic [31:0] NS_PER_MS  = 32'd1000000;
	localparam logic signed [43:0] MS_PER_SEC = 44'sd1000;
	localparam logic signed [43:0] LAST_BIN   = 44'(NUM_BINS - 1);

	logic [31:0] prev_sec_q;
	logic [29:0] prev_nsec_q;
	logic [31:0] event_total_q;
	logic [7:0]  discard_q;
	logic [31:0] total_next;
	logic        elig_next;

	logic               v_s1, v_s2, v_s3;
	logic               rd_s1, rd_s2, rd_s3;
	logic               elig_s1, elig_s2, elig_s3;
	logic [9:0]         idx_s1, idx_s2, idx_s3;
	logic signed [32:0] ds_s1;
	logic [31:0]        y_s1, y_s2;
	logic [63:0]        prod_s2;
	logic signed [43:0] ds1k_s2;
	logic signed [43:0] f_s3;
	logic               rnz_s3;

	logic [11:0] quot;
	logic [31:0] quot_ns;
	logic        neg, minus1, ms_large, last;

	assign total_next = (event_total_q == SAT_COUNT) ? event_total_q : event_total_q + 32'd1;
	assign elig_next  = (prev_sec_q != '0) && (total_next > {24'd0, discard_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sec_q    <= '0;
			prev_nsec_q   <= '0;
			event_total_q <= '0;
			discard_q     <= 8'd10;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				discard_q <= cfg_wr_data;
			end
			if (accept && req.command == CMD_EVENT) begin
				event_total_q <= total_next;
				prev_sec_q    <= req.time_sec;
				prev_nsec_q   <= req.time_nsec;
			end
			if (en) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	// The quotient of the biased term by one million; it stays below 4096.
	assign quot    = prod_s2[61:50];
	assign quot_ns = 32'(quot) * NS_PER_MS;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1   <= req.command;
			elig_s1 <= elig_next && (req.command == CMD_EVENT);
			idx_s1  <= req.bin_index;
			ds_s1   <= $signed({1'b0, req.time_sec}) - $signed({1'b0, prev_sec_q});
			y_s1    <= {2'b00, req.time_nsec} + NSEC_BIAS - {2'b00, prev_nsec_q};

			rd_s2   <= rd_s1;
			elig_s2 <= elig_s1;
			idx_s2  <= idx_s1;
			y_s2    <= y_s1;
			prod_s2 <= 64'(y_s1) * 64'(RECIP_MS);
			ds1k_s2 <= 44'(ds_s1) * MS_PER_SEC;

			rd_s3   <= rd_s2;
			elig_s3 <= elig_s2;
			idx_s3  <= idx_s2;
			f_s3    <= ds1k_s2 + $signed(44'(quot)) - $signed(44'(BIAS_MS));
			rnz_s3  <= (y_s2 != quot_ns);
		end
	end

	// f_s3 is the millisecond quotient rounded up (ceiling); truncation toward zero only
	// differs from it when it is positive with a nonzero remainder.
	assign neg      = f_s3[43];
	assign minus1   = (f_s3 == '1);
	assign ms_large = !neg && (f_s3[42:32] != '0);
	assign last     = !neg && (f_s3 >= LAST_BIN);

	always_comb begin
		op.valid    = v_s3;
		op.is_read  = rd_s3;
		op.recorded = v_s3 && !rd_s3 && elig_s3 && (!neg || (minus1 && rnz_s3));
		op.oob      = (32'(idx_s3) >= 32'(NUM_BINS));
		if (neg) begin
			op.ms = '0;
		end else if (ms_large) begin
			op.ms = SAT_COUNT;
		end else begin
			op.ms = f_s3[31:0];
		end
		if (rd_s3) begin
			addr = AW'(idx_s3);
		end else if (last) begin
			addr = AW'(NUM_BINS - 1);
		end else if (neg) begin
			addr = '0;
		end else begin
			addr = f_s3[AW-1:0];
		end
	end

endmodule

// ----- hw/rtl/eih_bins.sv -----
// Histogram bin store: clearing pass, read-modify-write with forwarding, response register.
module eih_bins #(
	parameter int NUM_BINS = 1024,
	localparam int AW = $clog2(NUM_BINS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  eih_pkg::eih_op_t  op,
	input  logic [AW-1:0]     addr,
	output logic              busy,
	output logic              rsp_valid,
	output eih_pkg::eih_rsp_t rsp
);

	import eih_pkg::*;

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	eih_op_t       op_s4;
	logic [AW-1:0] addr_s4;
	logic          lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	logic [31:0]   lw_data_q;
	logic [31:0]   longest_q;
	logic          rsp_valid_q;
	eih_rsp_t      rsp_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   rdata;
	logic [31:0]   cur;
	logic [31:0]   inc;
	logic [31:0]   new_max;
	logic          upd;

	eih_ram #(
		.WIDTH(32),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (en && op.valid),
		.raddr(addr),
		.rdata(rdata)
	);

	// The last write may have landed in the same cycle as the read.
	assign cur     = (lw_valid_q && lw_addr_q == addr_s4) ? lw_data_q : rdata;
	assign inc     = (cur == SAT_COUNT) ? cur : cur + 32'd1;
	assign upd     = en && op_s4.valid && op_s4.recorded;
	assign new_max = (op_s4.recorded && op_s4.ms > longest_q) ? op_s4.ms : longest_q;

	assign ram_we    = clr_q || upd;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s4;
	assign ram_wdata = clr_q ? '0 : inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			op_s4       <= '0;
			lw_valid_q  <= 1'b0;
			longest_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(NUM_BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (upd) begin
				lw_valid_q <= 1'b1;
			end
			if (en) begin
				op_s4       <= op;
				rsp_valid_q <= op_s4.valid;
				if (op_s4.valid) begin
					longest_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s4 <= addr;
			if (op_s4.valid) begin
				rsp_q.bin_count         <= (op_s4.is_read && !op_s4.oob) ? cur : '0;
				rsp_q.max_period_ms     <= new_max;
				rsp_q.interval_recorded <= op_s4.recorded;
			end
		end
		if (upd) begin
			lw_addr_q <= addr_s4;
			lw_data_q <= inc;
		end
	end

	assign busy      = clr_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/event_interval_histogram.sv -----
// Top level of the event interval histogram.
//
// Requests enter on in_valid/in_stall/in_data. A timestamp event counts the
// event and, once past the discard threshold, bins the interval to the
// previous event in whole milliseconds (rounded up); a read request returns
// the count of one bin. Every request yields exactly one response on
// out_valid/out_stall/out_data, carrying the bin count and the longest
// interval so far.
//
// One request is taken every clock cycle while in_stall is low. A response
// follows its accepted request through the interval arithmetic registers
// (one 32x32 reciprocal multiply for the millisecond division), the bin
// memory read and the response register. Back-to-back events that
// hit the same bin are served by forwarding the last bin write.
//
// After reset the bin memory is cleared one entry per cycle through all
// NUM_BINS entries, and in_stall stays high until that pass is done; the
// discard_events register may be written meanwhile. When the receiver stalls
// a valid response, the pipeline holds and in_stall rises in the same cycle.
module event_interval_histogram #(
	parameter int NUM_BINS = 1024,
	localparam int AW = $clog2(NUM_BINS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  eih_pkg::eih_req_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output eih_pkg::eih_rsp_t out_data,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data
);

	import eih_pkg::*;

	logic          en;
	logic          accept;
	logic          busy;
	eih_op_t       op;
	logic [AW-1:0] addr;

	// The pipeline moves whenever the response register is empty or taken.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en || busy;
	assign accept   = in_valid && !in_stall;

	eih_interval #(
		.NUM_BINS(NUM_BINS)
	) u_interval (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.accept     (accept),
		.req        (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.op         (op),
		.addr       (addr)
	);

	eih_bins #(
		.NUM_BINS(NUM_BINS)
	) u_bins (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.op       (op),
		.addr     (addr),
		.busy     (busy),
		.rsp_valid(out_valid),
		.rsp      (out_data)
	);

endmodule
